FILE: sv/surface_pair_relaxation_step_defines.svh
// Assertion macros for the surface pair relaxation step checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SURFACE_PAIR_RELAXATION_STEP_DEFINES_SVH
`define SURFACE_PAIR_RELAXATION_STEP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SPRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SPRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_pkg
// Widths, mode codes and fixed constants of the surface pair relaxation step.
// ----------------------------------------------------------------------------
package sprs_pkg;

    localparam int RAD_W = 48;
    localparam int ACC_W = 44;
    localparam int IDX_W = 16;
    localparam int MODE_W = 2;

    // Point table depth: a power of two, so an index is reduced by its low bits
    localparam int ENTRIES = 65536;

    // Datapath widths
    localparam int V_W   = 50;   // 2r + dr
    localparam int SQ_W  = 100;  // v * v
    localparam int MUL_W = 150;  // shift-add accumulator
    localparam int EN_W  = 144;  // g * v * v
    localparam int NUM_W = 120;  // R^2 * 2^24
    localparam int DEN_W = 106;  // 1000 * r^2

    localparam int MUL_STEPS = 50;
    localparam int DIV_STEPS = 48;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [RAD_W-1:0] RESET_RADIUS = 48'd106887643136000;
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

endpackage

FILE: sv/sprs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_if
// Channel interfaces: request items, result items and the configuration write.
// ----------------------------------------------------------------------------
interface sprs_req_if;
    logic                          valid;
    logic                          ready;
    logic [sprs_pkg::MODE_W-1:0]   mode;
    logic [sprs_pkg::IDX_W-1:0]    first_index;
    logic [sprs_pkg::IDX_W-1:0]    second_index;
    logic [sprs_pkg::RAD_W-1:0]    radius_in;
    logic [sprs_pkg::ACC_W-1:0]    accel_in;

    modport source (output valid, mode, first_index, second_index, radius_in, accel_in,
                    input ready);
    modport sink (input valid, mode, first_index, second_index, radius_in, accel_in,
                  output ready);
endinterface

interface sprs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          moved;
    logic [sprs_pkg::RAD_W-1:0]    radius_out;
    logic [sprs_pkg::ACC_W-1:0]    accel_out;

    modport source (output valid, moved, radius_out, accel_out, input ready);
    modport sink (input valid, moved, radius_out, accel_out, output ready);
endinterface

interface sprs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sprs_pkg::RAD_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: sv/surface_pair_relaxation_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_pair_relaxation_step
// Table of surface points with load, read and pair relaxation step items.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per beat (mode, first_index, second_index, radius_in,
//   accel_in); rsp returns exactly one result beat per item. cfg writes the
//   reference radius R; it is always ready, and the user must write it only
//   while idle, which the block does not enforce. Indices are reduced modulo
//   ENTRIES by taking their low bits. A step that moves the pair writes both
//   radii back to the table, and a saturated move skips the divider steps.
//   The step time is set by one shared shift-add multiplier (seven products)
//   and one restoring divider (one quotient per side of the pair). req is
//   ready again in the same cycle that the result turns valid on rsp.
//   Items are handled one at a time; req is ready only when the sequencer is
//   idle, and a new item may be taken while the previous result waits on rsp.
//   When rsp stalls the result beat holds; a finished item then waits until
//   the output slot is free.
//   Reset clears the sequencer, the output valid and sets R to its default.
//   The point table itself is not cleared: read only entries that were loaded.
// ----------------------------------------------------------------------------
module surface_pair_relaxation_step (
    input  logic       clk,
    input  logic       rst_n,
    sprs_req_if.sink   req,
    sprs_rsp_if.source rsp,
    sprs_cfg_if.sink   cfg
);

    localparam int AW = $clog2(sprs_pkg::ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RD_I, S_RD_J, S_CAP_J, S_RSQ, S_NUM, S_DSQ,
        S_DEN, S_DCHK, S_DIV, S_DDONE, S_VEC, S_ESQ, S_ESET, S_EG, S_ECMP,
        S_WR_I, S_WR_J, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic [sprs_pkg::RAD_W-1:0] ref_radius_reg;

    // Item registers
    logic [sprs_pkg::MODE_W-1:0] mode_reg;
    logic [AW-1:0]               idx_i_reg, idx_j_reg;
    logic [sprs_pkg::RAD_W-1:0]  rad_in_reg;
    logic [sprs_pkg::ACC_W-1:0]  acc_in_reg;
    logic [5:0]                  cnt_reg;
    logic                        side_reg;

    logic [sprs_pkg::RAD_W-1:0]  ri_reg, rj_reg, dri_reg, drj_reg;
    logic [sprs_pkg::ACC_W-1:0]  gi_reg, gj_reg;
    logic [sprs_pkg::V_W-1:0]    vj_reg;

    // Arithmetic registers
    logic [sprs_pkg::SQ_W-1:0]   mul_a_reg;
    logic [sprs_pkg::V_W-1:0]    mul_b_reg;
    logic [sprs_pkg::MUL_W-1:0]  prod_reg;
    logic [sprs_pkg::NUM_W-1:0]  num_reg;
    logic [sprs_pkg::DEN_W-1:0]  den_reg;
    logic [sprs_pkg::DEN_W-1:0]  rem_reg;
    logic [sprs_pkg::RAD_W-1:0]  nlo_reg, quo_reg;
    logic [sprs_pkg::EN_W-1:0]   ei_reg;

    // Result registers
    logic                        res_m_reg;
    logic [sprs_pkg::RAD_W-1:0]  res_r_reg;
    logic [sprs_pkg::ACC_W-1:0]  res_g_reg;
    logic                        out_m_reg;
    logic [sprs_pkg::RAD_W-1:0]  out_r_reg;
    logic [sprs_pkg::ACC_W-1:0]  out_g_reg;

    // Point table
    logic [sprs_pkg::RAD_W-1:0]  rad_mem [sprs_pkg::ENTRIES];
    logic [sprs_pkg::ACC_W-1:0]  acc_mem [sprs_pkg::ENTRIES];
    logic [sprs_pkg::RAD_W-1:0]  rd_r_reg;
    logic [sprs_pkg::ACC_W-1:0]  rd_g_reg;

    logic                        mem_we;
    logic [AW-1:0]               mem_addr;
    logic [sprs_pkg::RAD_W-1:0]  mem_wr_r;
    logic [sprs_pkg::ACC_W-1:0]  mem_wr_g;

    logic req_acc, out_free, mul_done, div_sat, less;
    logic [AW-1:0] idx_i, idx_j;
    logic [sprs_pkg::MUL_W-1:0] prod_next;
    logic [sprs_pkg::DEN_W:0] rem_sh;
    logic [sprs_pkg::RAD_W:0] ri_sum;
    logic [sprs_pkg::RAD_W-1:0] ri_new, rj_new;
    logic [sprs_pkg::V_W-1:0] vi_val, vj_val, two_rj;
    logic [sprs_pkg::DEN_W-1:0] sq_ext;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.moved  = out_m_reg;
    assign rsp.radius_out = out_r_reg;
    assign rsp.accel_out  = out_g_reg;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign idx_i = idx_i_reg;
    assign idx_j = idx_j_reg;

    // Shift-add multiplier step, multiplier taken MSB first
    assign prod_next = (prod_reg << 1)
                     + (mul_b_reg[sprs_pkg::V_W-1] ? sprs_pkg::MUL_W'(mul_a_reg)
                                                   : '0);
    assign mul_done  = (cnt_reg == 6'(sprs_pkg::MUL_STEPS - 1));

    // Divider: saturation test and one restoring step
    assign div_sat = {{(sprs_pkg::DEN_W + sprs_pkg::RAD_W - sprs_pkg::NUM_W){1'b0}}, num_reg}
                     >= {den_reg, {sprs_pkg::RAD_W{1'b0}}};
    assign rem_sh  = {rem_reg, nlo_reg[sprs_pkg::RAD_W-1]};
    assign sq_ext  = sprs_pkg::DEN_W'(prod_reg[95:0]);

    // Move vectors and written-back radii
    assign vi_val = {1'b0, ri_reg, 1'b0} + sprs_pkg::V_W'(dri_reg);
    assign two_rj = {1'b0, rj_reg, 1'b0};
    assign vj_val = (two_rj >= sprs_pkg::V_W'(drj_reg)) ? two_rj - sprs_pkg::V_W'(drj_reg)
                                                       : sprs_pkg::V_W'(drj_reg) - two_rj;
    assign ri_sum = {1'b0, ri_reg} + {1'b0, dri_reg};
    assign ri_new = ri_sum[sprs_pkg::RAD_W] ? sprs_pkg::RAD_MAX : ri_sum[sprs_pkg::RAD_W-1:0];
    assign rj_new = (rj_reg > drj_reg) ? rj_reg - drj_reg : '0;
    assign less   = ei_reg < prod_reg[sprs_pkg::EN_W-1:0];

    // Table port selection
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = idx_i;
        mem_wr_r = rad_in_reg;
        mem_wr_g = acc_in_reg;
        case (state_reg)
            S_LOAD:
            begin
                mem_we = 1'b1;
            end
            S_RD_J:
            begin
                mem_addr = idx_j;
            end
            S_WR_I:
            begin
                mem_we   = 1'b1;
                mem_wr_r = ri_new;
                mem_wr_g = gi_reg;
            end
            S_WR_J:
            begin
                mem_we   = 1'b1;
                mem_addr = idx_j;
                mem_wr_r = rj_new;
                mem_wr_g = gj_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Point table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rad_mem[mem_addr] <= mem_wr_r;
            acc_mem[mem_addr] <= mem_wr_g;
        end
        rd_r_reg <= rad_mem[mem_addr];
        rd_g_reg <= acc_mem[mem_addr];
    end

    // Sequencer state, result valid and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            ref_radius_reg <= sprs_pkg::RESET_RADIUS;
        end
        else
        begin
            if (cfg.valid)
            begin
                ref_radius_reg <= cfg.data;
            end
            // Raise valid for a finished item, drop it once the beat is taken
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        state_reg <= (req.mode == sprs_pkg::MODE_LOAD) ? S_LOAD : S_RD_I;
                    end
                end
                S_LOAD:  state_reg <= S_OUT;
                S_RD_I:  state_reg <= S_RD_J;
                S_RD_J:
                begin
                    state_reg <= (mode_reg == sprs_pkg::MODE_STEP && idx_i != idx_j)
                                 ? S_CAP_J : S_OUT;
                end
                S_CAP_J: state_reg <= S_RSQ;
                S_RSQ:   if (mul_done) state_reg <= S_NUM;
                S_NUM:   state_reg <= S_DSQ;
                S_DSQ:   if (mul_done) state_reg <= S_DEN;
                S_DEN:   state_reg <= S_DCHK;
                S_DCHK:  state_reg <= div_sat ? S_DDONE : S_DIV;
                S_DIV:
                begin
                    if (cnt_reg == 6'(sprs_pkg::DIV_STEPS - 1)) state_reg <= S_DDONE;
                end
                S_DDONE: state_reg <= side_reg ? S_VEC : S_DSQ;
                S_VEC:   state_reg <= S_ESQ;
                S_ESQ:   if (mul_done) state_reg <= S_ESET;
                S_ESET:  state_reg <= S_EG;
                S_EG:    if (mul_done) state_reg <= S_ECMP;
                S_ECMP:
                begin
                    if (!side_reg)
                        state_reg <= S_ESQ;
                    else
                        state_reg <= less ? S_WR_I : S_OUT;
                end
                S_WR_I:  state_reg <= S_WR_J;
                S_WR_J:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    mode_reg   <= req.mode;
                    idx_i_reg  <= req.first_index[AW-1:0];
                    idx_j_reg  <= req.second_index[AW-1:0];
                    rad_in_reg <= req.radius_in;
                    acc_in_reg <= req.accel_in;
                end
            end
            S_LOAD:
            begin
                res_m_reg <= 1'b0;
                res_r_reg <= rad_in_reg;
                res_g_reg <= acc_in_reg;
            end
            S_RD_J:
            begin
                ri_reg    <= rd_r_reg;
                gi_reg    <= rd_g_reg;
                res_m_reg <= 1'b0;
                res_r_reg <= rd_r_reg;
                res_g_reg <= rd_g_reg;
            end
            S_CAP_J:
            begin
                rj_reg    <= rd_r_reg;
                gj_reg    <= rd_g_reg;
                side_reg  <= 1'b0;
                mul_a_reg <= sprs_pkg::SQ_W'(ref_radius_reg);
                mul_b_reg <= sprs_pkg::V_W'(ref_radius_reg);
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            S_RSQ, S_DSQ, S_ESQ, S_EG:
            begin
                prod_reg  <= prod_next;
                mul_b_reg <= mul_b_reg << 1;
                cnt_reg   <= cnt_reg + 6'd1;
            end
            S_NUM:
            begin
                num_reg   <= {prod_reg[95:0], 24'd0};
                mul_a_reg <= sprs_pkg::SQ_W'(ri_reg);
                mul_b_reg <= sprs_pkg::V_W'(ri_reg);
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            S_DEN:
            begin
                den_reg <= (sq_ext << 10) - (sq_ext << 4) - (sq_ext << 3);
            end
            S_DCHK:
            begin
                quo_reg <= div_sat ? sprs_pkg::RAD_MAX : '0;
                rem_reg <= sprs_pkg::DEN_W'(num_reg[sprs_pkg::NUM_W-1:sprs_pkg::RAD_W]);
                nlo_reg <= num_reg[sprs_pkg::RAD_W-1:0];
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= sprs_pkg::DEN_W'(rem_sh - {1'b0, den_reg});
                    quo_reg <= {quo_reg[sprs_pkg::RAD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[sprs_pkg::DEN_W-1:0];
                    quo_reg <= {quo_reg[sprs_pkg::RAD_W-2:0], 1'b0};
                end
                nlo_reg <= nlo_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_DDONE:
            begin
                if (!side_reg)
                begin
                    dri_reg   <= quo_reg;
                    side_reg  <= 1'b1;
                    mul_a_reg <= sprs_pkg::SQ_W'(rj_reg);
                    mul_b_reg <= sprs_pkg::V_W'(rj_reg);
                    prod_reg  <= '0;
                    cnt_reg   <= '0;
                end
                else
                begin
                    drj_reg <= quo_reg;
                end
            end
            S_VEC:
            begin
                vj_reg    <= vj_val;
                side_reg  <= 1'b0;
                mul_a_reg <= sprs_pkg::SQ_W'(vi_val);
                mul_b_reg <= vi_val;
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            S_ESET:
            begin
                mul_a_reg <= prod_reg[sprs_pkg::SQ_W-1:0];
                mul_b_reg <= side_reg ? sprs_pkg::V_W'(gj_reg) : sprs_pkg::V_W'(gi_reg);
                prod_reg  <= '0;
                cnt_reg   <= '0;
            end
            S_ECMP:
            begin
                if (!side_reg)
                begin
                    ei_reg    <= prod_reg[sprs_pkg::EN_W-1:0];
                    side_reg  <= 1'b1;
                    mul_a_reg <= sprs_pkg::SQ_W'(vj_reg);
                    mul_b_reg <= vj_reg;
                    prod_reg  <= '0;
                    cnt_reg   <= '0;
                end
            end
            S_WR_I:
            begin
                res_m_reg <= 1'b1;
                res_r_reg <= ri_new;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_m_reg <= res_m_reg;
                    out_r_reg <= res_r_reg;
                    out_g_reg <= res_g_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

FILE: sv/sprs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprs_checker
// Port-level checks on the surface pair relaxation step, bound to the top.
// ----------------------------------------------------------------------------
`include "surface_pair_relaxation_step_defines.svh"

module sprs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_moved,
    input logic [sprs_pkg::RAD_W-1:0]  rsp_radius_out,
    input logic [sprs_pkg::ACC_W-1:0]  rsp_accel_out
);

    // Hold a stalled result beat
    `SPRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")
    `SPRS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_moved) && $stable(rsp_radius_out) && $stable(rsp_accel_out), "rsp payload changed while stalled")

    // One item at a time: the request side closes after a beat is taken
    `SPRS_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready, "req ready after accept")

    // Every item passes through the table before its result is raised
    `SPRS_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, !$rose(rsp_valid), "result too early")

endmodule

bind surface_pair_relaxation_step sprs_checker u_sprs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_moved      (rsp.moved),
    .rsp_radius_out (rsp.radius_out),
    .rsp_accel_out  (rsp.accel_out)
);
